/* hdl/dtq_pkg.sv */
package dtq_pkg;

    localparam int DTQ_DAYS                = 256;
    localparam int DTQ_POWER_TABLE_ENTRIES = 256;

    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 32;
    localparam int DAY_W     = 8;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int DCOUNT_W  = 9;
    localparam int SCALE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DCOUNT_W-1:0] DAY_COUNT_RESET = 9'd256;
    localparam logic [SCALE_W-1:0]  SCALE_RESET     = 32'h0001_0000;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DAY_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 2'd1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DAY   = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] mag;
        logic [DAY_W-1:0]    day;
        logic                day_ok;
    } item_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_TERM0,
        ST_TERM1,
        ST_TERM2,
        ST_TERM3,
        ST_TRI0,
        ST_TRI1,
        ST_TRI2,
        ST_TRI3,
        ST_RD0,
        ST_RD1,
        ST_RD2
    } back_state_t;

endpackage

/* hdl/dtq_if.sv */
interface dtq_in_if;
    import dtq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] return_sample;
    logic [DAY_W-1:0]           day_index;

    modport source (output valid, mode, return_sample, day_index, input ready);
    modport sink   (input valid, mode, return_sample, day_index, output ready);
endinterface

interface dtq_out_if;
    import dtq_pkg::*;
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  day_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, day_value, status, input ready);
    modport sink   (input valid, day_value, status, output ready);
endinterface

interface dtq_cfg_if;
    import dtq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dtq_queue.sv */
module dtq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dtq_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output dtq_pkg::item_t  head,
    output logic            head_valid
);
    import dtq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/dtq_front.sv */
module dtq_front #(
    parameter int DAYS = dtq_pkg::DTQ_DAYS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dtq_in_if.sink                       samples,
    dtq_cfg_if.sink                      cfg,
    input  logic                         queue_full,
    output logic                         push,
    output dtq_pkg::item_t               push_item,
    output logic [dtq_pkg::SCALE_W-1:0]  inverse_scale
);
    import dtq_pkg::*;

    logic [DCOUNT_W-1:0] day_count_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SAMPLE_W-1:0] raw;
    logic                below_count;
    logic                below_days;

    assign cfg.ready     = 1'b1;
    assign inverse_scale = scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_count_reg <= DAY_COUNT_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_DAY_COUNT)
            begin
                day_count_reg <= cfg.data[DCOUNT_W-1:0];
            end
            else if (cfg.index == CFG_INVERSE_SCALE)
            begin
                scale_reg <= cfg.data[SCALE_W-1:0];
            end
        end
    end

    assign samples.ready = !queue_full;
    assign push          = samples.valid && !queue_full;

    assign raw         = samples.return_sample;
    assign below_count = {1'b0, samples.day_index} < day_count_reg;
    assign below_days  = (DAYS > 255) || (samples.day_index < DAY_W'(DAYS));

    always_comb
    begin
        push_item.mag    = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
        push_item.day    = samples.day_index;
        push_item.day_ok = below_count && below_days;
        case (samples.mode)
            MODE_PUSH:  push_item.op = OP_PUSH;
            MODE_READ:  push_item.op = OP_READ;
            MODE_CLEAR: push_item.op = OP_CLEAR;
            default:    push_item.op = OP_NONE;
        endcase
    end

endmodule

/* hdl/dtq_back.sv */
module dtq_back #(
    parameter int DAYS                = dtq_pkg::DTQ_DAYS,
    parameter int POWER_TABLE_ENTRIES = dtq_pkg::DTQ_POWER_TABLE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dtq_pkg::item_t               head,
    input  logic                         head_valid,
    output logic                         pop,
    input  logic [dtq_pkg::SCALE_W-1:0]  inverse_scale,
    dtq_out_if.source                    results
);
    import dtq_pkg::*;

    localparam int DAY_AW = (DAYS > 1) ? $clog2(DAYS) : 1;
    localparam int IDX_W  = $clog2(POWER_TABLE_ENTRIES + 1);
    localparam int FRAC_W = 31;
    localparam int POS_W  = SAMPLE_W + IDX_W;
    localparam logic [VALUE_W-1:0] MAX64 = '1;

    function automatic logic [31:0] pow_entry(input int unsigned k);
        logic [63:0] kk;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] c;
        kk  = 64'(k);
        q   = (64'd1 << 63) / 64'(POWER_TABLE_ENTRIES);
        rem = (64'd1 << 63) % 64'(POWER_TABLE_ENTRIES);
        v   = kk * q + (kk * rem) / 64'(POWER_TABLE_ENTRIES);
        r   = '0;
        for (int b = 21; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c <= (64'd1 << 21) && c * c * c <= v)
            begin
                r = c;
            end
        end
        return 32'(((kk * r) << 10) / 64'(POWER_TABLE_ENTRIES));
    endfunction

    logic [31:0] pow_rom [POWER_TABLE_ENTRIES + 1];

    for (genvar k = 0; k <= POWER_TABLE_ENTRIES; k++)
    begin : g_rom
        assign pow_rom[k] = pow_entry(k);
    end

    logic [VALUE_W-1:0] totals_mem [DAYS];
    logic [VALUE_W-1:0] rd_data_reg;

    back_state_t state_reg;
    back_state_t state_next;
    logic [DAY_AW:0] wipe_reg;

    logic [31:0] older_term_reg;
    logic [31:0] newer_term_reg;
    logic [7:0]  older_day_reg;
    logic [7:0]  newer_day_reg;
    logic [1:0]  hist_count_reg;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    status_t             out_status_reg;

    item_t              item_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        diff_reg;
    logic [62:0]        interp_reg;
    logic [31:0]        t1_reg;
    logic [31:0]        t2_reg;
    logic [31:0]        t3_reg;
    logic [63:0]        a_reg;
    logic [63:0]        hp_reg;
    logic [63:0]        lp_reg;
    logic [63:0]        p_reg;
    logic               p_ovf_reg;

    logic               out_free;
    logic               wipe_done;
    logic [DAY_AW-1:0]  item_addr;
    logic [DAY_AW-1:0]  head_addr;
    logic [POS_W-1:0]   pos;
    logic [IDX_W-1:0]   hi_idx;
    logic [31:0]        lo_val;
    logic [31:0]        hi_val;
    logic [31:0]        term;
    logic               triple;
    logic [34:0]        tri_lp;
    logic [64:0]        tri_sum;
    logic [64:0]        acc_sum;
    logic               acc_sat;
    logic [47:0]        rd_lp;
    logic [64:0]        rd_sum;
    logic               rd_sat;

    logic               mem_we;
    logic [DAY_AW-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [DAY_AW-1:0]  mem_raddr;
    logic               res_load;
    logic [VALUE_W-1:0] res_value;
    status_t            res_status;
    logic               hist_clear;

    assign out_free  = !out_valid_reg || results.ready;
    assign wipe_done = (wipe_reg == (DAY_AW + 1)'(DAYS - 1));
    assign item_addr = DAY_AW'(item_reg.day);
    assign head_addr = DAY_AW'(head.day);

    assign pos    = POS_W'(item_reg.mag) * POS_W'(POWER_TABLE_ENTRIES);
    assign hi_idx = (idx_reg >= IDX_W'(POWER_TABLE_ENTRIES)) ? IDX_W'(POWER_TABLE_ENTRIES)
                                                             : idx_reg + 1'b1;
    assign lo_val = pow_rom[idx_reg];
    assign hi_val = pow_rom[hi_idx];
    assign term   = lo_reg + interp_reg[62:31];
    assign triple = (hist_count_reg >= 2'd2) && (older_day_reg == item_reg.day)
                    && (newer_day_reg == item_reg.day);

    assign tri_lp  = lp_reg[63:29];
    assign tri_sum = {1'b0, hp_reg[60:0], 3'b000} + {30'd0, tri_lp};
    assign acc_sum = {1'b0, rd_data_reg} + {1'b0, p_reg};
    assign acc_sat = p_ovf_reg || acc_sum[64];

    assign rd_lp  = lp_reg[63:16];
    assign rd_sum = {1'b0, hp_reg[47:0], 16'd0} + {17'd0, rd_lp};
    assign rd_sat = (hp_reg[63:48] != '0) || rd_sum[64];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WIPE:
            begin
                if (wipe_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop && head.day_ok && head.op == OP_PUSH)
                begin
                    state_next = ST_TERM0;
                end
                else if (pop && head.day_ok && head.op == OP_READ)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_TERM0: state_next = ST_TERM1;
            ST_TERM1: state_next = ST_TERM2;
            ST_TERM2: state_next = ST_TERM3;
            ST_TERM3: state_next = triple ? ST_TRI0 : ST_IDLE;
            ST_TRI0:  state_next = ST_TRI1;
            ST_TRI1:  state_next = ST_TRI2;
            ST_TRI2:  state_next = ST_TRI3;
            ST_TRI3:  state_next = ST_IDLE;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = item_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = item_addr;
        res_load   = 1'b0;
        res_value  = '0;
        res_status = STATUS_OK;
        hist_clear = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                mem_we    = 1'b1;
                mem_waddr = wipe_reg[DAY_AW-1:0];
            end
            ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_PUSH:
                        begin
                            if (!head.day_ok)
                            begin
                                hist_clear = 1'b1;
                                res_load   = 1'b1;
                                res_status = STATUS_BAD_DAY;
                            end
                        end
                        OP_READ:
                        begin
                            if (!head.day_ok)
                            begin
                                res_load   = 1'b1;
                                res_status = STATUS_BAD_DAY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            hist_clear = 1'b1;
                            res_load   = 1'b1;
                            if (head.day_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = head_addr;
                            end
                            else
                            begin
                                res_status = STATUS_BAD_DAY;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_TERM3:
            begin
                if (triple)
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    res_load = 1'b1;
                end
            end
            ST_TRI3:
            begin
                mem_we     = 1'b1;
                mem_wdata  = acc_sat ? MAX64 : acc_sum[63:0];
                res_load   = 1'b1;
                res_status = acc_sat ? STATUS_SATURATED : STATUS_OK;
            end
            ST_RD0:
            begin
                mem_re = 1'b1;
            end
            ST_RD2:
            begin
                res_load   = 1'b1;
                res_value  = rd_sat ? MAX64 : rd_sum[63:0];
                res_status = rd_sat ? STATUS_SATURATED : STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            totals_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= totals_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        if (res_load)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
        case (state_reg)
            ST_TERM0:
            begin
                idx_reg  <= pos[FRAC_W +: IDX_W];
                frac_reg <= pos[FRAC_W-1:0];
            end
            ST_TERM1:
            begin
                lo_reg   <= lo_val;
                diff_reg <= (hi_val < lo_val) ? 32'd0 : hi_val - lo_val;
            end
            ST_TERM2:
            begin
                interp_reg <= diff_reg * frac_reg;
            end
            ST_TERM3:
            begin
                t1_reg <= older_term_reg;
                t2_reg <= newer_term_reg;
                t3_reg <= term;
            end
            ST_TRI0:
            begin
                a_reg <= t1_reg * t2_reg;
            end
            ST_TRI1:
            begin
                hp_reg <= a_reg[63:32] * t3_reg;
                lp_reg <= a_reg[31:0] * t3_reg;
            end
            ST_TRI2:
            begin
                p_reg     <= tri_sum[63:0];
                p_ovf_reg <= (hp_reg[63:61] != '0) || tri_sum[64];
            end
            ST_RD1:
            begin
                hp_reg <= rd_data_reg[63:32] * inverse_scale;
                lp_reg <= rd_data_reg[31:0] * inverse_scale;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_WIPE;
            wipe_reg       <= '0;
            older_term_reg <= '0;
            newer_term_reg <= '0;
            older_day_reg  <= '0;
            newer_day_reg  <= '0;
            hist_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WIPE)
            begin
                wipe_reg <= wipe_reg + 1'b1;
            end
            if (hist_clear)
            begin
                hist_count_reg <= '0;
            end
            else if (state_reg == ST_TERM3)
            begin
                older_term_reg <= newer_term_reg;
                older_day_reg  <= newer_day_reg;
                newer_term_reg <= term;
                newer_day_reg  <= item_reg.day;
                if (hist_count_reg < 2'd2)
                begin
                    hist_count_reg <= hist_count_reg + 1'b1;
                end
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.day_value = out_value_reg;
    assign results.status    = out_status_reg;

    a_no_pop_in_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WIPE |-> !pop)
        else $error("item taken during clearing pass");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || results.ready))
        else $error("result overwrites a pending item");

    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hist_count_reg != 2'd3)
        else $error("history count out of range");

    a_single_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in one cycle");

endmodule

/* hdl/daily_tripower_quarticity.sv */
// Per-day tripower quarticity accumulator. Push items (mode 0) turn |r| into |r|^(4/3)
// by table interpolation and, when three consecutive pushes share a day, add the triple
// product to that day's saturating 64-bit total; reads (mode 1) return the total scaled by
// inverse_scale (Q16.16); clears (mode 2) zero a day and drop the sample history. Every
// item returns exactly one result. After reset the day store is swept to zero, one entry
// per cycle, for every day before the first item is processed; configuration writes are
// taken at any time. Items are queued in a two-entry queue and executed one at a time by a
// shared sequencer: a push computes its term (interpolation multiply) and, if it completes
// a triple, the product (two multiply stages) and a read-modify-write of the day total;
// a valid read does a memory read, two partial products and a sum; other items end in idle.
module daily_tripower_quarticity #(
    parameter int DAYS                = dtq_pkg::DTQ_DAYS,
    parameter int POWER_TABLE_ENTRIES = dtq_pkg::DTQ_POWER_TABLE_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    dtq_in_if.sink     samples,
    dtq_out_if.source  results,
    dtq_cfg_if.sink    cfg
);
    import dtq_pkg::*;

    logic                queue_full;
    logic                push;
    item_t               push_item;
    logic                pop;
    item_t               head;
    logic                head_valid;
    logic [SCALE_W-1:0]  inverse_scale;

    dtq_front #(
        .DAYS (DAYS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .cfg           (cfg),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item),
        .inverse_scale (inverse_scale)
    );

    dtq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    dtq_back #(
        .DAYS                (DAYS),
        .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .inverse_scale (inverse_scale),
        .results       (results)
    );

endmodule

/* bench/daily_tripower_quarticity_test.sv */
module daily_tripower_quarticity_test;
    import dtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [VALUE_W-1:0]  day_value;
        logic [STATUS_W-1:0] status;
    } day_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dtq_in_if  samples ();
    dtq_out_if results ();
    dtq_cfg_if cfg ();

    daily_tripower_quarticity dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [31:0]        term_table [0:DTQ_POWER_TABLE_ENTRIES];
    logic [63:0]        totals [0:DTQ_DAYS-1];
    logic [31:0]        older_term, newer_term;
    logic [7:0]         older_day, newer_day;
    int                 seen_count;
    logic [8:0]         day_limit;
    logic [31:0]        read_scale;
    day_result_t        expected_results [$];
    int                 failures = 0;
    int                 send_idle_pct = 0;
    int                 take_idle_pct = 0;
    int                 quiet_cycles = 0;

    function automatic logic [63:0] cube_root_down(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 21; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c <= (64'd1 << 21) && c * c * c <= v)
                r = c;
        end
        return r;
    endfunction

    task automatic build_term_table();
        logic [63:0] n, q, rm, v, c;
        n = DTQ_POWER_TABLE_ENTRIES;
        q = (64'd1 << 63) / n;
        rm = (64'd1 << 63) % n;
        for (int k = 0; k <= DTQ_POWER_TABLE_ENTRIES; k++)
        begin
            v = 64'(k) * q + (64'(k) * rm) / n;
            c = cube_root_down(v);
            term_table[k] = 32'(((64'(k) * c) << 10) / n);
        end
    endtask

    function automatic logic [31:0] power_term(logic [63:0] mag);
        logic [63:0] pos, idx, frac, lo, hi;
        pos = mag * DTQ_POWER_TABLE_ENTRIES;
        idx = pos >> 31;
        frac = pos & 64'h7FFF_FFFF;
        if (idx >= DTQ_POWER_TABLE_ENTRIES)
            return term_table[DTQ_POWER_TABLE_ENTRIES];
        lo = term_table[idx];
        hi = term_table[idx + 1];
        if (hi < lo)
            hi = lo;
        return 32'(lo + (((hi - lo) * frac) >> 31));
    endfunction

    function automatic day_result_t predict_day_result(logic [1:0] mode, logic [31:0] raw,
                                                       logic [7:0] day);
        day_result_t res;
        logic        ok;
        logic [63:0] mag;
        logic [31:0] t;
        logic [127:0] prod, wide;
        ok = (9'(day) < day_limit) && (int'(day) < DTQ_DAYS);
        res.day_value = '0;
        res.status = STATUS_OK;
        if (mode == MODE_PUSH)
        begin
            if (!ok)
            begin
                res.status = STATUS_BAD_DAY;
                seen_count = 0;
            end
            else
            begin
                mag = raw[31] ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
                t = power_term(mag);
                if (seen_count >= 2 && older_day == day && newer_day == day)
                begin
                    prod = (128'(older_term) * 128'(newer_term) * 128'(t)) >> 29;
                    wide = prod + 128'(totals[day]);
                    if (wide[127:64] != 0)
                    begin
                        totals[day] = '1;
                        res.status = STATUS_SATURATED;
                    end
                    else
                        totals[day] = wide[63:0];
                end
                older_term = newer_term;
                older_day = newer_day;
                newer_term = t;
                newer_day = day;
                if (seen_count < 2)
                    seen_count++;
            end
        end
        else if (mode == MODE_READ)
        begin
            if (!ok)
                res.status = STATUS_BAD_DAY;
            else
            begin
                wide = (128'(totals[day]) * 128'(read_scale)) >> 16;
                if (wide[127:64] != 0)
                begin
                    res.day_value = '1;
                    res.status = STATUS_SATURATED;
                end
                else
                    res.day_value = wide[63:0];
            end
        end
        else if (mode == MODE_CLEAR)
        begin
            seen_count = 0;
            if (!ok)
                res.status = STATUS_BAD_DAY;
            else
                totals[day] = '0;
        end
        return res;
    endfunction

    initial
    begin
        samples.valid = 1'b0;
        samples.mode = '0;
        samples.return_sample = '0;
        samples.day_index = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            results.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin
        day_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result day_value=%h status=%0d",
                       results.day_value, results.status);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (results.day_value !== want.day_value)
                begin
                    $error("day_value expected %h actual %h", want.day_value,
                           results.day_value);
                    failures++;
                end
                if (results.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, results.status);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("daily_tripower_quarticity regression: fail");
            $finish;
        end
    end

    // valid stays high after an accept; the next idle cycle or drain drops it
    task automatic send_item(logic [1:0] mode, logic [31:0] raw, logic [7:0] day);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.mode <= mode;
        samples.return_sample <= raw;
        samples.day_index <= day;
        do
            @(posedge clk);
        while (!samples.ready);
        expected_results.push_back(predict_day_result(mode, raw, day));
    endtask

    task automatic drain_results();
        samples.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (index == CFG_DAY_COUNT)
            day_limit = value[8:0];
        else if (index == CFG_INVERSE_SCALE)
            read_scale = value;
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(MODE_READ, 0, 0);
        send_item(MODE_PUSH, 32'h7FFF_FFFF, 5);
        send_item(MODE_PUSH, 32'h8000_0000, 5);
        send_item(MODE_PUSH, 32'hFFFF_FFFF, 5);
        send_item(MODE_PUSH, 32'h8000_0000, 5);
        send_item(MODE_PUSH, 32'h0000_0000, 5);
        send_item(MODE_READ, 0, 5);
        send_item(2'd3, 32'h1234_5678, 5);
        send_item(MODE_READ, 0, 255);
        send_item(MODE_CLEAR, 0, 5);
        send_item(MODE_READ, 0, 5);
        send_item(MODE_PUSH, 32'h4000_0000, 9);
        send_item(MODE_PUSH, 32'hC000_0000, 9);
        send_item(MODE_CLEAR, 0, 200);
        send_item(MODE_PUSH, 32'h4000_0000, 9);
    endtask

    // hammer one day with full-scale triples until it saturates
    task automatic test_saturation();
        write_register(CFG_INVERSE_SCALE, 32'hFFFF_FFFF);
        for (int i = 0; i < 40; i++)
            send_item(MODE_PUSH, 32'h8000_0000, 3);
        send_item(MODE_READ, 0, 3);
        send_item(MODE_CLEAR, 0, 3);
        send_item(MODE_READ, 0, 3);
        write_register(CFG_INVERSE_SCALE, 32'd0);
        send_item(MODE_READ, 0, 5);
    endtask

    task automatic test_day_limits();
        write_register(CFG_DAY_COUNT, 9'd1);
        send_item(MODE_PUSH, 32'h8000_0000, 1);
        send_item(MODE_READ, 0, 1);
        send_item(MODE_CLEAR, 0, 1);
        send_item(MODE_READ, 0, 0);
        write_register(CFG_DAY_COUNT, 9'd0);
        send_item(MODE_PUSH, 32'h8000_0000, 0);
        send_item(MODE_READ, 0, 0);
        write_register(CFG_DAY_COUNT, 9'h1FF);
        send_item(MODE_READ, 0, 255);
        write_register(CFG_DAY_COUNT, 9'd256);
    endtask

    task automatic run_random(int count, int day_span);
        int          sent;
        logic [7:0]  day;
        sent = 0;
        while (sent < count)
        begin
            day = 8'($urandom_range(day_span));
            if ($urandom_range(9) < 7)
            begin
                for (int k = $urandom_range(6, 2); k > 0 && sent < count; k--)
                begin
                    send_item(MODE_PUSH, random_sample(), day);
                    sent++;
                end
                if ($urandom_range(1))
                begin
                    send_item(MODE_READ, 0, day);
                    sent++;
                end
            end
            else
            begin
                send_item(2'($urandom_range(3)), $urandom, 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        write_register(CFG_INVERSE_SCALE, $urandom);
        write_register(CFG_DAY_COUNT, 9'd200);
        send_idle_pct = 30;
        take_idle_pct = 61;
        run_random(400, 255);
        drain_results();
        write_register(CFG_INVERSE_SCALE, 32'd65536);
        send_idle_pct = 61;
        take_idle_pct = 30;
        run_random(400, 15);
        write_register(CFG_DAY_COUNT, 9'd256);
        write_register(CFG_INVERSE_SCALE, $urandom);
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_random(400, 255);
    endtask

    initial
    begin
        build_term_table();
        for (int d = 0; d < DTQ_DAYS; d++)
            totals[d] = '0;
        older_term = '0;
        newer_term = '0;
        older_day = '0;
        newer_day = '0;
        seen_count = 0;
        day_limit = DAY_COUNT_RESET;
        read_scale = SCALE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_day_limits();
        test_random();
        drain_results();
        if (failures == 0)
            $display("daily_tripower_quarticity regression: pass");
        else
            $display("daily_tripower_quarticity regression: fail");
        $finish;
    end
endmodule

/* files.f */
hdl/dtq_pkg.sv
hdl/dtq_if.sv
hdl/dtq_queue.sv
hdl/dtq_front.sv
hdl/dtq_back.sv
hdl/daily_tripower_quarticity.sv
bench/daily_tripower_quarticity_test.sv
